/* sv/planar_byterun1_body_decoder_macros.svh */
// ----------------------------------------------------------------------------
// planar_byterun1_body_decoder_macros.svh
// Assertion macros for the planar ByteRun1 body decoder.
// ----------------------------------------------------------------------------
`ifndef PLANAR_BYTERUN1_BODY_DECODER_MACROS_SVH
`define PLANAR_BYTERUN1_BODY_DECODER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define PBR1_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbr1 assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PBR1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbr1 assertion failed");

`else

`define PBR1_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PBR1_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/pbr1_pkg.sv */
// ----------------------------------------------------------------------------
// pbr1_pkg
// Shared types and constants of the planar ByteRun1 body decoder.
// ----------------------------------------------------------------------------
package pbr1_pkg;

    // Limits of the supported image geometry
    localparam int MAX_ROW_BYTES = 1024;
    localparam int MAX_ROWS      = 4096;
    localparam int MAX_PLANES    = 8;

    // Column position saturates here so that it never wraps on overrun
    localparam logic [10:0] COL_SAT = 11'(MAX_ROW_BYTES + 256);

    // Run header that does nothing
    localparam logic [7:0] NOOP_HEADER = 8'd128;

    // Configuration register widths and reset values
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [10:0] RST_ROW_BYTES    = 11'd40;
    localparam logic [12:0] RST_ROW_COUNT    = 13'd200;
    localparam logic [3:0]  RST_PLANE_COUNT  = 4'd1;
    localparam logic        RST_MASK_PRESENT = 1'b0;
    localparam logic        RST_COMPRESSED   = 1'b1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW_BYTES    = 3'd0,
        CFG_ROW_COUNT    = 3'd1,
        CFG_PLANE_COUNT  = 3'd2,
        CFG_MASK_PRESENT = 3'd3,
        CFG_COMPRESSED   = 3'd4
    } t_cfg_addr;

    // Run decoder phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } t_phase;

    // Effective (already clamped) configuration
    typedef struct packed {
        logic [10:0] row_bytes;    // 1..MAX_ROW_BYTES
        logic [12:0] row_count;    // 1..MAX_ROWS
        logic [3:0]  plane_count;  // 1..MAX_PLANES
        logic [3:0]  plane_total;  // kept planes plus mask plane
        logic        compressed;
    } t_cfg;

endpackage

/* sv/pbr1_in_if.sv */
// ----------------------------------------------------------------------------
// pbr1_in_if
// Byte stream channel into the decoder.
// ----------------------------------------------------------------------------
interface pbr1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;
    logic       first_byte;

    modport source (output valid, output body_byte, output first_byte, input ready);
    modport sink   (input valid, input body_byte, input first_byte, output ready);
endinterface

/* sv/pbr1_out_if.sv */
// ----------------------------------------------------------------------------
// pbr1_out_if
// Write descriptor channel out of the decoder.
// ----------------------------------------------------------------------------
interface pbr1_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  plane;
    logic [11:0] row;
    logic [9:0]  column;
    logic [7:0]  value;
    logic [7:0]  count;
    logic        keep;
    logic        overrun;
    logic        last;

    modport source (
        output valid, output plane, output row, output column, output value,
        output count, output keep, output overrun, output last, input ready
    );
    modport sink (
        input valid, input plane, input row, input column, input value,
        input count, input keep, input overrun, input last, output ready
    );
endinterface

/* sv/pbr1_cfg_if.sv */
// ----------------------------------------------------------------------------
// pbr1_cfg_if
// Register write channel of the decoder.
// ----------------------------------------------------------------------------
interface pbr1_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pbr1_pkg::CFG_ADDR_W-1:0]    addr;
    logic [pbr1_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

/* sv/pbr1_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pbr1_cfg_regs
// Configuration registers; values are clamped to their legal range on write.
// ----------------------------------------------------------------------------
module pbr1_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbr1_cfg_if.sink          i_cfg,
    output pbr1_pkg::t_cfg    o_cfg
);
    import pbr1_pkg::*;

    logic [10:0] r_row_bytes;
    logic [12:0] r_row_count;
    logic [3:0]  r_plane_count;
    logic        r_mask_present;
    logic        r_compressed;

    logic [10:0] n_row_bytes;
    logic [12:0] n_row_count;
    logic [3:0]  n_plane_count;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;

    // Clamp: zero acts as one, anything above the limit acts as the limit
    always_comb begin
        if (i_cfg.wdata[10:0] == 11'd0) begin
            n_row_bytes = 11'd1;
        end else if (i_cfg.wdata[10:0] > 11'(MAX_ROW_BYTES)) begin
            n_row_bytes = 11'(MAX_ROW_BYTES);
        end else begin
            n_row_bytes = i_cfg.wdata[10:0];
        end

        if (i_cfg.wdata[12:0] == 13'd0) begin
            n_row_count = 13'd1;
        end else if (i_cfg.wdata[12:0] > 13'(MAX_ROWS)) begin
            n_row_count = 13'(MAX_ROWS);
        end else begin
            n_row_count = i_cfg.wdata[12:0];
        end

        if (i_cfg.wdata[3:0] == 4'd0) begin
            n_plane_count = 4'd1;
        end else if (i_cfg.wdata[3:0] > 4'(MAX_PLANES)) begin
            n_plane_count = 4'(MAX_PLANES);
        end else begin
            n_plane_count = i_cfg.wdata[3:0];
        end
    end

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes    <= RST_ROW_BYTES;
            r_row_count    <= RST_ROW_COUNT;
            r_plane_count  <= RST_PLANE_COUNT;
            r_mask_present <= RST_MASK_PRESENT;
            r_compressed   <= RST_COMPRESSED;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                CFG_ROW_BYTES:    r_row_bytes    <= n_row_bytes;
                CFG_ROW_COUNT:    r_row_count    <= n_row_count;
                CFG_PLANE_COUNT:  r_plane_count  <= n_plane_count;
                CFG_MASK_PRESENT: r_mask_present <= i_cfg.wdata[0];
                CFG_COMPRESSED:   r_compressed   <= i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.row_bytes   = r_row_bytes;
    assign o_cfg.row_count   = r_row_count;
    assign o_cfg.plane_count = r_plane_count;
    assign o_cfg.plane_total = r_plane_count + 4'(r_mask_present);
    assign o_cfg.compressed  = r_compressed;

endmodule

/* sv/planar_byterun1_body_decoder.sv */
// ----------------------------------------------------------------------------
// planar_byterun1_body_decoder
// Decodes the body of an interleaved planar image, raw or ByteRun1 coded,
// into write descriptors (plane, row, column, value, count).
//
// One body byte is taken per clock cycle while the input is not stalled: each
// byte updates the run phase and the row/plane/column counters in the cycle it
// is accepted, and its descriptor (if any) appears in the output register on
// the next cycle. Header bytes and bytes after the end of the body give no
// descriptor. The input only stalls while a descriptor sits in the output
// register and the sink holds ready low. A byte with first_byte set restarts
// the position at row 0, plane 0, column 0. Registers are written through the
// configuration channel, which is always ready, and are clamped to their
// legal range when written.
// ----------------------------------------------------------------------------
`include "planar_byterun1_body_decoder_macros.svh"

module planar_byterun1_body_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbr1_in_if.sink     i_in,
    pbr1_out_if.source  o_out,
    pbr1_cfg_if.sink    i_cfg
);
    import pbr1_pkg::*;

    t_cfg cfg;

    // Decoder state
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_lit_left,  n_lit_left;
    logic [7:0]  r_rep_len,   n_rep_len;
    logic [10:0] r_col_pos,   n_col_pos;
    logic [3:0]  r_plane_pos, n_plane_pos;
    logic [12:0] r_row_pos,   n_row_pos;
    logic        r_body_done, n_body_done;

    // Output register
    logic        r_out_valid;
    logic [3:0]  r_plane;
    logic [11:0] r_row;
    logic [9:0]  r_column;
    logic [7:0]  r_value;
    logic [7:0]  r_count;
    logic        r_keep;
    logic        r_overrun;
    logic        r_last;

    // State seen by the current item after an optional restart
    t_phase      cur_phase;
    logic [7:0]  cur_lit_left;
    logic [7:0]  cur_rep_len;
    logic [10:0] cur_col;
    logic [3:0]  cur_plane;
    logic [12:0] cur_row;
    logic        cur_done;

    // Write descriptor built for the current item
    logic        do_emit;
    logic        e_run_done;
    logic [7:0]  e_value;
    logic [7:0]  e_count;
    logic        e_keep;
    logic        e_overrun;
    logic        e_last;
    logic [11:0] col_sum;
    logic [10:0] col_new;
    logic [7:0]  lit_dec;
    logic [3:0]  plane_inc;
    logic [12:0] row_inc;

    logic        in_accept;

    // Terms used by the checks
    logic        runs_idle;
    logic        idle_taken;

    pbr1_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Output register parts the two sides
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Restart clears position before the byte is taken
    always_comb begin
        if (i_in.first_byte) begin
            cur_phase    = PH_HEADER;
            cur_lit_left = 8'd0;
            cur_rep_len  = 8'd0;
            cur_col      = 11'd0;
            cur_plane    = 4'd0;
            cur_row      = 13'd0;
            cur_done     = 1'b0;
        end else begin
            cur_phase    = r_phase;
            cur_lit_left = r_lit_left;
            cur_rep_len  = r_rep_len;
            cur_col      = r_col_pos;
            cur_plane    = r_plane_pos;
            cur_row      = r_row_pos;
            cur_done     = r_body_done;
        end
    end

    // Run decoding and position advance
    always_comb begin
        n_phase     = cur_phase;
        n_lit_left  = cur_lit_left;
        n_rep_len   = cur_rep_len;
        n_col_pos   = cur_col;
        n_plane_pos = cur_plane;
        n_row_pos   = cur_row;
        n_body_done = cur_done;

        do_emit    = 1'b0;
        e_run_done = 1'b1;
        e_value    = i_in.body_byte;
        e_count    = 8'd1;
        e_last     = 1'b0;
        lit_dec    = (cur_lit_left != 8'd0) ? cur_lit_left - 8'd1 : 8'd0;

        if (!cur_done) begin
            if (!cfg.compressed) begin
                // raw byte, run phase left untouched
                do_emit = 1'b1;
            end else begin
                unique case (cur_phase)
                    PH_LITERAL: begin
                        n_lit_left = lit_dec;
                        if (lit_dec == 8'd0) begin
                            n_phase = PH_HEADER;
                        end
                        do_emit    = 1'b1;
                        e_run_done = (lit_dec == 8'd0);
                    end
                    PH_REPEAT: begin
                        n_phase   = PH_HEADER;
                        n_rep_len = 8'd0;
                        e_count   = (cur_rep_len == 8'd0) ? 8'd1 : cur_rep_len;
                        do_emit   = 1'b1;
                    end
                    default: begin
                        // run header; the no-op code leaves everything as is
                        if (i_in.body_byte < NOOP_HEADER) begin
                            n_lit_left = i_in.body_byte + 8'd1;
                            n_phase    = PH_LITERAL;
                        end else if (i_in.body_byte > NOOP_HEADER) begin
                            n_rep_len = 8'(9'd257 - {1'b0, i_in.body_byte});
                            n_phase   = PH_REPEAT;
                        end
                    end
                endcase
            end
        end

        // column advance with saturation
        col_sum   = {1'b0, cur_col} + {4'd0, e_count};
        col_new   = (col_sum > {1'b0, COL_SAT}) ? COL_SAT : col_sum[10:0];
        e_overrun = (col_sum > {1'b0, cfg.row_bytes});
        e_keep    = (cur_plane < cfg.plane_count);
        plane_inc = cur_plane + 4'd1;
        row_inc   = cur_row + 13'd1;

        if (do_emit) begin
            n_col_pos = col_new;
            if (e_run_done && col_new >= cfg.row_bytes) begin
                n_col_pos   = 11'd0;
                n_plane_pos = plane_inc;
                if (plane_inc >= cfg.plane_total) begin
                    n_plane_pos = 4'd0;
                    n_row_pos   = row_inc;
                    if (row_inc >= cfg.row_count) begin
                        n_row_pos   = 13'd0;
                        n_body_done = 1'b1;
                        n_phase     = PH_HEADER;
                        n_lit_left  = 8'd0;
                        n_rep_len   = 8'd0;
                        e_last      = 1'b1;
                    end
                end
            end
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_lit_left  <= 8'd0;
            r_rep_len   <= 8'd0;
            r_col_pos   <= 11'd0;
            r_plane_pos <= 4'd0;
            r_row_pos   <= 13'd0;
            r_body_done <= 1'b0;
        end else if (in_accept) begin
            r_phase     <= n_phase;
            r_lit_left  <= n_lit_left;
            r_rep_len   <= n_rep_len;
            r_col_pos   <= n_col_pos;
            r_plane_pos <= n_plane_pos;
            r_row_pos   <= n_row_pos;
            r_body_done <= n_body_done;
        end
    end

    // Result register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= in_accept && do_emit;
        end
    end

    // Result register: payload
    always_ff @(posedge i_clk) begin
        if (in_accept && do_emit) begin
            r_plane   <= cur_plane;
            r_row     <= cur_row[11:0];
            r_column  <= cur_col[9:0];
            r_value   <= e_value;
            r_count   <= e_count;
            r_keep    <= e_keep;
            r_overrun <= e_overrun;
            r_last    <= e_last;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.plane   = r_plane;
    assign o_out.row     = r_row;
    assign o_out.column  = r_column;
    assign o_out.value   = r_value;
    assign o_out.count   = r_count;
    assign o_out.keep    = r_keep;
    assign o_out.overrun = r_overrun;
    assign o_out.last    = r_last;

    // Checks
    assign runs_idle  = r_phase == PH_HEADER && r_lit_left == 8'd0 && r_rep_len == 8'd0;
    assign idle_taken = in_accept && r_body_done && !i_in.first_byte;

    `PBR1_ASSERT_IMPLIES(a_col_saturated, i_clk, i_rst_n, 1'b1, r_col_pos <= COL_SAT)
    `PBR1_ASSERT_IMPLIES(a_done_idle_runs, i_clk, i_rst_n, r_body_done, runs_idle)
    `PBR1_ASSERT_IMPLIES(a_literal_nonzero, i_clk, i_rst_n, r_phase == PH_LITERAL, r_lit_left != 8'd0)
    `PBR1_ASSERT_NEXT(a_no_write_after_done, i_clk, i_rst_n, idle_taken, !r_out_valid)

endmodule
